### sv/tlbvat_pkg.sv
`timescale 1ns / 1ps

package tlbvat_pkg;

  localparam int TLB_ENTRIES = 32;
  localparam int IDX_W       = $clog2(TLB_ENTRIES);
  localparam int CNT_W       = $clog2(TLB_ENTRIES + 1);

  localparam logic CMD_WRITE     = 1'b0;
  localparam logic CMD_TRANSLATE = 1'b1;

  typedef enum logic [1:0] {
    FAULT_NONE    = 2'd0,
    FAULT_MISS    = 2'd1,
    FAULT_INVALID = 2'd2,
    FAULT_MOD     = 2'd3
  } fault_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_FORM = 3'b100
  } state_e;

  // Only the fields of the high word that take part in a lookup are kept.
  typedef struct packed {
    logic [1:0]  region;
    logic [26:0] vpn2;
    logic [7:0]  asid;
    logic [11:0] page_mask;
    logic [25:0] lo_even;
    logic [25:0] lo_odd;
    logic        glb;
  } tlb_entry_t;

endpackage

### sv/tlb_virtual_address_translation_unit.sv
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+-------------------------------------
// command   | in        | start_i && !busy_o        | cmd_i, entry_*_i, virtual_address_i,
//           |           |                           | is_store_i
// result    | out       | done_o (one-cycle strobe) | translated_o, physical_address_o,
//           |           |                           | fault_code_o, hit_found_o, hit_index_o
// asid cfg  | in        | current_asid_we_i         | current_asid_i
//
// A write transfer stores the entry at the accept edge; the acknowledge strobes
// in the next cycle, while busy_o stays low.
// A translate transfer walks the entries through the single read port of the entry
// memory, one per cycle, lowest index first; the walk stops at the first match.
// A hit at entry k goes on to a check of the selected low word before the result
// strobes; a miss strobes once the last entry has been compared.
// Reset clears the valid bits at once, so no clearing pass is needed; an entry
// never written reads as all zero. The result receiver cannot stall.

module tlb_virtual_address_translation_unit
  import tlbvat_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cmd_i,
  input  logic [4:0]  entry_index_i,
  input  logic [63:0] entry_high_i,
  input  logic [11:0] entry_page_mask_i,
  input  logic [25:0] entry_low_even_i,
  input  logic [25:0] entry_low_odd_i,
  input  logic        entry_global_i,
  input  logic [31:0] virtual_address_i,
  input  logic        is_store_i,
  // ASID register
  input  logic        current_asid_we_i,
  input  logic [7:0]  current_asid_i,
  // result channel
  output logic        done_o,
  output logic        translated_o,
  output logic [31:0] physical_address_o,
  output logic [1:0]  fault_code_o,
  output logic        hit_found_o,
  output logic [4:0]  hit_index_o
);

  state_e state_q, state_d;

  logic [7:0] asid_q;

  // entry memory and per-entry valid bits
  tlb_entry_t                 mem_q [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0]     vld_q;
  tlb_entry_t                 rd_data_q;
  logic                       rd_vld_q;
  logic [IDX_W-1:0]           rd_idx_q;
  logic                       pend_q;

  // walk sequencer
  logic [CNT_W-1:0]           cnt_q;
  logic [31:0]                va_q;
  logic                       store_q;

  // result registers
  logic        done_q;
  logic        translated_q;
  logic [31:0] pa_q;
  fault_e      fault_q;
  logic        hit_found_q;
  logic [4:0]  hit_index_q;

  logic             accept;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  tlb_entry_t       wr_entry;
  logic             rd_en;
  tlb_entry_t       ent;
  logic [26:0]      vpn_diff;
  logic             match;
  logic             hit;
  logic             last;
  logic [12:0]      odd_sel;
  logic             odd;
  logic [25:0]      lo;
  logic [31:0]      pa;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // Writes beyond the table are dropped but still acknowledged.
  assign wr_en   = accept && (cmd_i == CMD_WRITE)
                   && (8'(entry_index_i) < 8'(TLB_ENTRIES));
  assign wr_addr = IDX_W'(entry_index_i);

  always_comb begin
    wr_entry.region    = entry_high_i[63:62];
    wr_entry.vpn2      = entry_high_i[39:13];
    wr_entry.asid      = entry_high_i[7:0];
    wr_entry.page_mask = entry_page_mask_i;
    wr_entry.lo_even   = entry_low_even_i;
    wr_entry.lo_odd    = entry_low_odd_i;
    wr_entry.glb       = entry_global_i;
  end

  // Entry under compare; an unwritten entry looks all zero.
  assign ent = rd_vld_q ? rd_data_q : '0;

  // VPN compare over bits 39:13; the mask clears bits 24:13. A 32-bit address
  // has no region bits, so a nonzero region never matches.
  assign vpn_diff = (ent.vpn2 ^ {8'b0, va_q[31:13]}) & ~{15'b0, ent.page_mask};
  assign match    = (ent.region == 2'b00) && (vpn_diff == '0)
                    && (ent.glb || (ent.asid == asid_q));
  assign hit      = pend_q && match;
  assign last     = (rd_idx_q == IDX_W'(TLB_ENTRIES - 1));
  assign rd_en    = (state_q == ST_WALK) && !hit && !(pend_q && last);

  // Odd page select: the address bit just above the page offset.
  assign odd_sel = {1'b0, ent.page_mask} + 13'd1;
  assign odd     = |(va_q[24:12] & odd_sel);
  assign lo      = odd ? ent.lo_odd : ent.lo_even;
  assign pa      = {lo[25:6], 12'b0} | {8'b0, va_q[23:12] & ent.page_mask, va_q[11:0]};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (cmd_i == CMD_TRANSLATE)) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (hit) begin
          state_d = ST_FORM;
        end else if (pend_q && last) begin
          state_d = ST_IDLE;
        end
      end
      ST_FORM: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[cnt_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      asid_q   <= '0;
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
      pend_q   <= 1'b0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      // strobe on a write acknowledge, at the end of a missed walk, or after the check
      done_q  <= (accept && (cmd_i == CMD_WRITE))
                 || ((state_q == ST_WALK) && !hit && pend_q && last)
                 || (state_q == ST_FORM);
      if (current_asid_we_i) begin
        asid_q <= current_asid_i;
      end
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (accept) begin
        cnt_q  <= '0;
        pend_q <= 1'b0;
      end
      if (rd_en) begin
        rd_vld_q <= vld_q[cnt_q[IDX_W-1:0]];
        rd_idx_q <= cnt_q[IDX_W-1:0];
        pend_q   <= 1'b1;
        cnt_q    <= cnt_q + CNT_W'(1);
      end
      if (state_q == ST_FORM) begin
        pend_q <= 1'b0;
      end
    end
  end

  // translate operands and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      va_q         <= virtual_address_i;
      store_q      <= is_store_i;
      translated_q <= 1'b0;
      pa_q         <= '0;
      fault_q      <= FAULT_NONE;
      hit_found_q  <= 1'b0;
      hit_index_q  <= '0;
    end
    if ((state_q == ST_WALK) && !hit && pend_q && last) begin
      fault_q <= FAULT_MISS;
    end
    if (state_q == ST_FORM) begin
      hit_found_q <= 1'b1;
      hit_index_q <= 5'(rd_idx_q);
      if (!lo[1]) begin
        fault_q <= FAULT_INVALID;
      end else if (store_q && !lo[2]) begin
        fault_q <= FAULT_MOD;
      end else begin
        translated_q <= 1'b1;
        pa_q         <= pa;
      end
    end
  end

  assign done_o             = done_q;
  assign translated_o       = translated_q;
  assign physical_address_o = pa_q;
  assign fault_code_o       = fault_q;
  assign hit_found_o        = hit_found_q;
  assign hit_index_o        = hit_index_q;

  // a result strobe never overlaps a running walk step; the check also admits the first
  // walk cycle of the next transfer, before any entry is pending
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ((state_q == ST_IDLE) || ((state_q == ST_WALK) && !pend_q)))
    else $error("result strobe while sequencer busy");

  // an accepted transfer either acknowledges or starts a walk
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (done_q || (state_q == ST_WALK)))
    else $error("accepted transfer made no progress");

  // a successful translation carries a hit and no fault
  a_translated_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && translated_q) |-> (hit_found_q && (fault_q == FAULT_NONE)))
    else $error("translation without hit");

  // the check cycle follows only a matching walk step
  a_form_after_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FORM) |-> ($past(state_q == ST_WALK) && pend_q))
    else $error("check cycle without a matched entry");

endmodule

### tb/tb_tlb_virtual_address_translation_unit.sv
`timescale 1ns / 1ps

module tb_tlb_virtual_address_translation_unit;
  import tlbvat_pkg::*;

  // Hard stop for a hung run.
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int MAX_REPORTS    = 100;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 260;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        cmd_i;
  logic [4:0]  entry_index_i;
  logic [63:0] entry_high_i;
  logic [11:0] entry_page_mask_i;
  logic [25:0] entry_low_even_i;
  logic [25:0] entry_low_odd_i;
  logic        entry_global_i;
  logic [31:0] virtual_address_i;
  logic        is_store_i;
  logic        current_asid_we_i;
  logic [7:0]  current_asid_i;
  logic        done_o;
  logic        translated_o;
  logic [31:0] physical_address_o;
  logic [1:0]  fault_code_o;
  logic        hit_found_o;
  logic [4:0]  hit_index_o;

  tlb_virtual_address_translation_unit DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .cmd_i              (cmd_i),
    .entry_index_i      (entry_index_i),
    .entry_high_i       (entry_high_i),
    .entry_page_mask_i  (entry_page_mask_i),
    .entry_low_even_i   (entry_low_even_i),
    .entry_low_odd_i    (entry_low_odd_i),
    .entry_global_i     (entry_global_i),
    .virtual_address_i  (virtual_address_i),
    .is_store_i         (is_store_i),
    .current_asid_we_i  (current_asid_we_i),
    .current_asid_i     (current_asid_i),
    .done_o             (done_o),
    .translated_o       (translated_o),
    .physical_address_o (physical_address_o),
    .fault_code_o       (fault_code_o),
    .hit_found_o        (hit_found_o),
    .hit_index_o        (hit_index_o)
  );

  // One translation outcome; a write acknowledge is all zero.
  typedef struct {
    logic        translated;
    logic [31:0] phys;
    fault_e      fault;
    logic        hit;
    logic [4:0]  hit_idx;
  } xlat_result_t;

  // Outcomes still owed by the block, oldest first.
  xlat_result_t pending_results[$];
  xlat_result_t due;

  // Shadow copy of the entry store and the ASID register.
  logic [63:0] shadow_high    [TLB_ENTRIES];
  logic [11:0] shadow_mask    [TLB_ENTRIES];
  logic [25:0] shadow_lo_even [TLB_ENTRIES];
  logic [25:0] shadow_lo_odd  [TLB_ENTRIES];
  logic        shadow_glb     [TLB_ENTRIES];
  logic [7:0]  shadow_asid;

  int mismatches;
  int cycle_count;
  int n_writes, n_ok, n_miss, n_invalid, n_mod, n_asid_writes;
  bit no_idle;

  // Clock: 10 ns period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Page number as the lookup sees it: region bits 63:62 folded down to 41:40,
  // then the in-page bits and the mask-covered bits 24:13 cleared.
  function automatic logic [63:0] page_number_of(logic [63:0] x, logic [11:0] pm);
    logic [63:0] folded;
    logic [63:0] clear;
    folded = (x & 64'h0000_00FF_FFFF_FFFF) | ((x >> 22) & 64'h0000_0300_0000_0000);
    clear  = (64'(pm) << 13) | 64'h1FFF;
    return folded & ~clear;
  endfunction

  // First-match walk, then valid / dirty checks on the selected half of the pair.
  function automatic xlat_result_t predict_translation(logic [31:0] va, logic st);
    xlat_result_t r;
    int           hit;
    logic [31:0]  off_mask;
    logic [25:0]  lo;
    r.translated = 1'b0;
    r.phys       = '0;
    r.fault      = FAULT_NONE;
    r.hit        = 1'b0;
    r.hit_idx    = '0;
    hit          = -1;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (hit < 0 &&
          page_number_of(shadow_high[i], shadow_mask[i]) ==
          page_number_of({32'h0, va}, shadow_mask[i]) &&
          (shadow_glb[i] || shadow_high[i][7:0] == shadow_asid))
        hit = i;
    end
    if (hit < 0) begin
      r.fault = FAULT_MISS;
      return r;
    end
    r.hit     = 1'b1;
    r.hit_idx = 5'(hit);
    off_mask  = {8'h00, shadow_mask[hit], 12'hFFF};
    // odd-page select: the bit just above the offset (taken as is for odd masks)
    lo = ((va & (off_mask + 32'd1)) != 0) ? shadow_lo_odd[hit] : shadow_lo_even[hit];
    if (!lo[1]) begin
      r.fault = FAULT_INVALID;
    end else if (st && !lo[2]) begin
      r.fault = FAULT_MOD;
    end else begin
      r.translated = 1'b1;
      r.phys       = {lo[25:6], 12'h000} | (va & off_mask);
    end
    return r;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Entered and left at a falling edge. start_i stays high on return so that the
  // next transfer can follow without a bubble.
  task automatic send_item(input logic c, input logic [4:0] idx, input logic [63:0] hi,
                           input logic [11:0] pm, input logic [25:0] le,
                           input logic [25:0] lo, input logic g,
                           input logic [31:0] va, input logic st);
    xlat_result_t r;
    int           gap;
    gap = pick_gap();
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_i             = c;
    entry_index_i     = idx;
    entry_high_i      = hi;
    entry_page_mask_i = pm;
    entry_low_even_i  = le;
    entry_low_odd_i   = lo;
    entry_global_i    = g;
    virtual_address_i = va;
    is_store_i        = st;
    start_i           = 1'b1;
    // busy_o read right after the edge is its value before the edge
    do @(posedge clk_i); while (busy_o);
    if (c == CMD_WRITE) begin
      shadow_high[idx]    = hi;
      shadow_mask[idx]    = pm;
      shadow_lo_even[idx] = le;
      shadow_lo_odd[idx]  = lo;
      shadow_glb[idx]     = g;
      r.translated = 1'b0;
      r.phys       = '0;
      r.fault      = FAULT_NONE;
      r.hit        = 1'b0;
      r.hit_idx    = '0;
      n_writes++;
    end else begin
      r = predict_translation(va, st);
      case (r.fault)
        FAULT_NONE:    n_ok++;
        FAULT_MISS:    n_miss++;
        FAULT_INVALID: n_invalid++;
        default:       n_mod++;
      endcase
    end
    pending_results.push_back(r);
    @(negedge clk_i);
  endtask

  // Translate-side fields are don't-care on a write; drive them random anyway.
  task automatic write_entry(input logic [4:0] idx, input logic [63:0] hi,
                             input logic [11:0] pm, input logic [25:0] le,
                             input logic [25:0] lo, input logic g);
    send_item(CMD_WRITE, idx, hi, pm, le, lo, g, $urandom, 1'($urandom));
  endtask

  task automatic translate(input logic [31:0] va, input logic st);
    send_item(CMD_TRANSLATE, 5'($urandom), {$urandom, $urandom}, 12'($urandom),
              26'($urandom), 26'($urandom), 1'($urandom), va, st);
  endtask

  // ASID changes only with the block idle and nothing outstanding.
  task automatic set_asid(input logic [7:0] v);
    start_i = 1'b0;
    while (pending_results.size() != 0 || busy_o) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    current_asid_we_i = 1'b1;
    current_asid_i    = v;
    @(negedge clk_i);
    current_asid_we_i = 1'b0;
    shadow_asid       = v;
    n_asid_writes++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Result monitor: every done_o strobe is matched against the oldest outcome owed.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: result transfer with nothing outstanding, expected none, actual %0h",
                 $time, physical_address_o);
      end else begin
        due = pending_results.pop_front();
        check_field("translated",       32'(due.translated), 32'(translated_o));
        check_field("physical_address", due.phys,            physical_address_o);
        check_field("fault_code",       32'(due.fault),      32'(fault_code_o));
        check_field("hit_found",        32'(due.hit),        32'(hit_found_o));
        check_field("hit_index",        32'(due.hit_idx),    32'(hit_index_o));
      end
    end
  end

  // Fresh store after reset: entry 0 (all zero) catches the low 8 KB and is invalid;
  // anything else misses.
  task automatic test_reset_contents();
    translate(32'h0000_0000, 1'b0);
    translate(32'h0000_1FFF, 1'b1);
    translate(32'hFFFF_FFFF, 1'b1);
  endtask

  // Largest page size, extreme frame numbers, region bits that block a match,
  // invalid and not-dirty halves, and a non-contiguous mask.
  task automatic test_page_sizes_and_faults();
    write_entry(5'd31, 64'h0000_0000_FE00_0000, 12'hFFF,
                {20'hFFFFF, 6'b000110}, {20'h00001, 6'b000010}, 1'b1);
    translate(32'hFEFF_FFFF, 1'b0);  // even half, all-ones physical address
    translate(32'hFF00_0000, 1'b1);  // odd half not dirty: modification fault
    translate(32'hFF00_1234, 1'b0);
    // region 3 in the high word: never matches a 32-bit address
    write_entry(5'd1, 64'hFFFF_FFFF_FFFF_FFFF, 12'h000, 26'h3FF_FFFF, 26'h3FF_FFFF, 1'b1);
    translate(32'hFFFF_E000, 1'b0);
    write_entry(5'd2, 64'h0000_0000_0040_0000, 12'h000, 26'h000_0000,
                {20'h12345, 6'b000110}, 1'b0);
    translate(32'h0040_0010, 1'b0);  // even half invalid
    translate(32'h0040_1010, 1'b1);  // odd half valid and dirty
    write_entry(5'd3, 64'h0000_0000_1234_6000, 12'hA5A,
                {20'hABCDE, 6'b000110}, {20'h13579, 6'b000010}, 1'b1);
    translate(32'h1234_6ABC, 1'b0);
    translate((32'h1234_6000 ^ (32'hA5A << 13)) | 32'h5A5, 1'b1);
    translate(32'h1234_6000 | 32'h0100_0000, 1'b0);
  endtask

  // ASID gating against global entries, and lowest index winning among matches.
  task automatic test_asid_and_priority();
    write_entry(5'd5, 64'h0000_0000_0080_007E, 12'h000,
                {20'h0000A, 6'b000110}, {20'h0000A, 6'b000110}, 1'b0);
    write_entry(5'd9, 64'h0000_0000_0080_0000, 12'h000,
                {20'h0000B, 6'b000110}, {20'h0000B, 6'b000110}, 1'b1);
    translate(32'h0080_0123, 1'b0);  // ASID 0: entry 5 skipped, global entry 9 hits
    set_asid(8'h7E);
    translate(32'h0080_0123, 1'b1);  // entry 5 now wins over 9
    write_entry(5'd4, 64'h0000_0000_0080_00FF, 12'h000,
                {20'hFFFFF, 6'b000110}, 26'h000_0000, 1'b0);
    set_asid(8'hFF);
    translate(32'h0080_0123, 1'b1);
    translate(32'h0080_1123, 1'b0);  // odd half of entry 4 invalid
  endtask

  // Phases at different ASIDs. Most writes are matchable entries (region 0,
  // upper VPN bits clear, usual page sizes); most translations aim at a stored
  // entry with random offset and masked bits. The rest is raw noise.
  task automatic test_random_traffic();
    logic [63:0] hi;
    logic [11:0] pm;
    logic [18:0] vpn;
    logic [7:0]  asid;
    logic [31:0] va;
    logic [31:0] clear32;
    int          k;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_asid(phase == 0 ? 8'h00 : phase == 1 ? 8'hFF : 8'($urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        no_idle = ((n / 40) % 3 == 2);
        if ($urandom_range(0, 99) < 30) begin
          if ($urandom_range(0, 4) == 0) begin
            hi = {$urandom, $urandom};
            pm = 12'($urandom);
          end else begin
            vpn  = $urandom_range(0, 1) ? 19'($urandom) : 19'($urandom_range(0, 15));
            asid = ($urandom_range(0, 2) != 0) ? shadow_asid : 8'($urandom);
            hi   = {2'b00, 22'($urandom), 8'h00, vpn, 5'($urandom), asid};
            pm   = ($urandom_range(0, 9) == 0) ? 12'($urandom)
                                               : 12'((1 << (2 * $urandom_range(0, 6))) - 1);
          end
          write_entry(5'($urandom), hi, pm,
                      {20'($urandom), 3'($urandom), 1'($urandom_range(0, 9) < 7),
                       1'($urandom_range(0, 19) < 17), 1'($urandom)},
                      {20'($urandom), 3'($urandom), 1'($urandom_range(0, 9) < 7),
                       1'($urandom_range(0, 19) < 17), 1'($urandom)},
                      1'($urandom_range(0, 3) == 0));
        end else begin
          if ($urandom_range(0, 3) != 0) begin
            k       = $urandom_range(0, TLB_ENTRIES - 1);
            clear32 = {7'h00, shadow_mask[k], 13'h1FFF};
            va      = (shadow_high[k][31:0] & ~clear32) | ($urandom & clear32);
          end else begin
            va = $urandom;
          end
          translate(va, 1'($urandom));
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni            = 1'b0;
    start_i           = 1'b0;
    cmd_i             = CMD_WRITE;
    entry_index_i     = '0;
    entry_high_i      = '0;
    entry_page_mask_i = '0;
    entry_low_even_i  = '0;
    entry_low_odd_i   = '0;
    entry_global_i    = 1'b0;
    virtual_address_i = '0;
    is_store_i        = 1'b0;
    current_asid_we_i = 1'b0;
    current_asid_i    = '0;
    shadow_asid       = '0;
    no_idle           = 1'b0;
    mismatches        = 0;
    cycle_count       = 0;
    n_writes = 0; n_ok = 0; n_miss = 0; n_invalid = 0; n_mod = 0; n_asid_writes = 0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      shadow_high[i]    = '0;
      shadow_mask[i]    = '0;
      shadow_lo_even[i] = '0;
      shadow_lo_odd[i]  = '0;
      shadow_glb[i]     = 1'b0;
    end
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_contents();
    test_page_sizes_and_faults();
    test_asid_and_priority();
    test_random_traffic();

    // drain, then leave room for any stray strobe
    start_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);

    $display("Coverage: %0d entry writes, %0d ASID updates; translations: %0d ok, %0d miss,",
             n_writes, n_asid_writes, n_ok, n_miss);
    $display("  %0d invalid, %0d modification; %0d field mismatches.",
             n_invalid, n_mod, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("Timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### tlb_virtual_address_translation_unit.f
sv/tlbvat_pkg.sv
sv/tlb_virtual_address_translation_unit.sv
tb/tb_tlb_virtual_address_translation_unit.sv
